FILE: rtl/hhbf_pkg.sv
// hhbf_pkg: shared constants and types for the http host block filter
// used by hhbf_core and http_host_block_filter; no dependencies
package hhbf_pkg;

  localparam int MAX_HOST         = 32;
  localparam int MAX_PACKET_BYTES = 65535;

  localparam int IDX_W    = 16;
  localparam int HLEN_W   = 6;
  localparam int WORD_W   = 64;
  localparam int NUM_WORD = 4;
  localparam int HOST_W   = NUM_WORD * WORD_W;
  localparam int CFG_A_W  = 3;

  localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_PACKET_BYTES);
  localparam logic [HLEN_W-1:0] HLEN_MAX = HLEN_W'(MAX_HOST);

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_HOST_WORD0 = 3'd0;
  localparam logic [CFG_A_W-1:0] CFG_HOST_WORD1 = 3'd1;
  localparam logic [CFG_A_W-1:0] CFG_HOST_WORD2 = 3'd2;
  localparam logic [CFG_A_W-1:0] CFG_HOST_WORD3 = 3'd3;
  localparam logic [CFG_A_W-1:0] CFG_HOST_LEN   = 3'd4;

  // CR LF "Host: " as seen in the shift register, oldest byte on top
  localparam logic [63:0] HOST_MARKER = 64'h0D0A486F73743A20;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [15:0] HTTP_PORT   = 16'd80;

  // verdict status codes
  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_DIFF  = 2'd1;
  localparam logic [1:0] ST_MATCH = 2'd2;

  typedef struct packed {
    logic       drop;
    logic [1:0] status;
  } hhbf_verdict_t;

endpackage

FILE: rtl/hhbf_core.sv
// hhbf_core: per-packet header parse, host marker search and host compare
// depends on hhbf_pkg; state updates on step, verdict is combinational
module hhbf_core
  import hhbf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          pkt_byte,
  input  logic                last_byte,
  input  logic [HOST_W-1:0]   host_bytes,
  input  logic [HLEN_W-1:0]   host_len_eff,
  output hhbf_verdict_t       verdict
);

  logic [IDX_W-1:0]  byte_index_r, byte_index_nxt;
  logic [HLEN_W-1:0] ip_hdr_r, ip_hdr_nxt;
  logic [15:0]       ip_total_r, ip_total_nxt;
  logic [7:0]        proto_r, proto_nxt;
  logic [HLEN_W-1:0] tcp_hdr_r, tcp_hdr_nxt;
  logic [15:0]       dest_port_r, dest_port_nxt;
  logic [63:0]       recent_r, recent_nxt;
  logic              found_r, found_nxt;
  logic [HLEN_W-1:0] cmp_count_r, cmp_count_nxt;
  logic              mismatch_r, mismatch_nxt;

  logic [IDX_W-1:0]  ihl_ext;
  logic [IDX_W-1:0]  tcp_ext;
  logic              in_payload;
  logic [7:0]        host_byte;
  logic [7:0]        host_sel;

  assign ihl_ext  = IDX_W'(ip_hdr_r);
  assign tcp_ext  = IDX_W'(tcp_hdr_r);
  assign host_sel = {cmp_count_r[4:0], 3'b000};
  assign host_byte = host_bytes[host_sel +: 8];

  assign in_payload = (byte_index_r != '0) &&
                      (byte_index_r >= ihl_ext + IDX_W'(13)) &&
                      (byte_index_r >= ihl_ext + tcp_ext) &&
                      (byte_index_r < ip_total_r);

  always_comb begin
    byte_index_nxt = byte_index_r;
    ip_hdr_nxt     = ip_hdr_r;
    ip_total_nxt   = ip_total_r;
    proto_nxt      = proto_r;
    tcp_hdr_nxt    = tcp_hdr_r;
    dest_port_nxt  = dest_port_r;
    recent_nxt     = recent_r;
    found_nxt      = found_r;
    cmp_count_nxt  = cmp_count_r;
    mismatch_nxt   = mismatch_r;

    // bytes past the size limit only count for their last flag
    if (byte_index_r < IDX_LIMIT) begin
      byte_index_nxt = byte_index_r + IDX_W'(1);
      if (byte_index_r == IDX_W'(0)) ip_hdr_nxt = {pkt_byte[3:0], 2'b00};
      if (byte_index_r == IDX_W'(2)) ip_total_nxt[15:8] = pkt_byte;
      if (byte_index_r == IDX_W'(3)) ip_total_nxt[7:0] = pkt_byte;
      if (byte_index_r == IDX_W'(9)) proto_nxt = pkt_byte;
      if (byte_index_r != '0) begin
        if (byte_index_r == ihl_ext + IDX_W'(2))  dest_port_nxt[15:8] = pkt_byte;
        if (byte_index_r == ihl_ext + IDX_W'(3))  dest_port_nxt[7:0] = pkt_byte;
        if (byte_index_r == ihl_ext + IDX_W'(12)) tcp_hdr_nxt = {pkt_byte[7:4], 2'b00};
      end
      if (in_payload) begin
        if (!found_r) begin
          recent_nxt = {recent_r[55:0], pkt_byte};
          if ({recent_r[55:0], pkt_byte} == HOST_MARKER) found_nxt = 1'b1;
        end else if (cmp_count_r < host_len_eff) begin
          if (pkt_byte != host_byte) mismatch_nxt = 1'b1;
          cmp_count_nxt = cmp_count_r + HLEN_W'(1);
        end
      end
    end
  end

  always_comb begin
    verdict.status = ST_NONE;
    if (proto_nxt == PROTO_TCP && dest_port_nxt == HTTP_PORT && found_nxt) begin
      if (mismatch_nxt || cmp_count_nxt < host_len_eff) begin
        verdict.status = ST_DIFF;
      end else begin
        verdict.status = ST_MATCH;
      end
    end
    verdict.drop = (verdict.status == ST_MATCH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      byte_index_r <= '0;
      ip_hdr_r     <= '0;
      ip_total_r   <= '0;
      proto_r      <= '0;
      tcp_hdr_r    <= '0;
      dest_port_r  <= '0;
      recent_r     <= '0;
      found_r      <= 1'b0;
      cmp_count_r  <= '0;
      mismatch_r   <= 1'b0;
    end else if (step) begin
      byte_index_r <= byte_index_nxt;
      ip_hdr_r     <= ip_hdr_nxt;
      ip_total_r   <= ip_total_nxt;
      proto_r      <= proto_nxt;
      tcp_hdr_r    <= tcp_hdr_nxt;
      dest_port_r  <= dest_port_nxt;
      recent_r     <= recent_nxt;
      found_r      <= found_nxt;
      cmp_count_r  <= cmp_count_nxt;
      mismatch_r   <= mismatch_nxt;
    end
  end

endmodule

FILE: rtl/http_host_block_filter.sv
// a verdict is registered onto out_tvalid when the last byte advances out of the input stage register
// throughput: one packet byte per cycle; in_tready drops only while a finished
//   verdict waits on out_tready and the next last byte is already registered
// reset: synchronous active-low rst_n clears the stream stages and packet state,
//   host words to zero and host_len to one
// top level of the http host block filter; depends on hhbf_pkg and hhbf_core
module http_host_block_filter
  import hhbf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] pkt_byte
  input  logic               in_tlast,   // last_byte
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,  // [0] drop, [2:1] status, [7:3] zero
  input  logic               cfg_wr_en,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [WORD_W-1:0]  cfg_wdata
);

  logic [WORD_W-1:0] host_r [NUM_WORD];
  logic [HLEN_W-1:0] host_len_r;
  logic [HLEN_W-1:0] host_len_eff;
  logic [HOST_W-1:0] host_bytes;

  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              s1_last_r;
  logic              s1_adv;

  logic              out_valid_r;
  hhbf_verdict_t     out_verdict_r;
  hhbf_verdict_t     verdict;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WORD; i++) host_r[i] <= '0;
      host_len_r <= HLEN_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_HOST_WORD0: host_r[0] <= cfg_wdata;
        CFG_HOST_WORD1: host_r[1] <= cfg_wdata;
        CFG_HOST_WORD2: host_r[2] <= cfg_wdata;
        CFG_HOST_WORD3: host_r[3] <= cfg_wdata;
        CFG_HOST_LEN:   host_len_r <= cfg_wdata[HLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    host_len_eff = host_len_r;
    if (host_len_r == '0) host_len_eff = HLEN_W'(1);
    else if (host_len_r > HLEN_MAX) host_len_eff = HLEN_MAX;
  end

  assign host_bytes = {host_r[3], host_r[2], host_r[1], host_r[0]};

  // a non-last byte never needs the output register
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  hhbf_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (s1_adv),
    .pkt_byte     (s1_byte_r),
    .last_byte    (s1_last_r),
    .host_bytes   (host_bytes),
    .host_len_eff (host_len_eff),
    .verdict      (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) out_verdict_r <= verdict;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_verdict_r.status, out_verdict_r.drop};

endmodule

FILE: rtl/hhbf_checker.sv
// hhbf_checker: port-level assertions for http_host_block_filter, bound below
// depends on hhbf_pkg
module hhbf_checker
  import hhbf_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [7:0]         out_tdata
);

  // a pending verdict holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("verdict changed while stalled");

  // drop is set exactly for a host match
  a_drop_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[2:1] == ST_MATCH)))
    else $error("drop does not follow status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:1] != 2'd3) && (out_tdata[7:3] == 5'd0))
    else $error("bad verdict encoding");

  // with the output empty the input side never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("verdict shown right after reset");

endmodule

bind http_host_block_filter hhbf_checker u_hhbf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
